/* sv/lir_pkg.sv */
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    // position and step: five integer bits, enough for the step maximum of 16 and for pos + step
    localparam int POS_BITS    = FRAC_BITS + 5;
    localparam int STEP_BITS   = FRAC_BITS + 5;
    localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [POS_BITS-1:0]  ONE_POS    = POS_BITS'(1) << FRAC_BITS;
    localparam logic [STEP_BITS-1:0] STEP_MIN   = STEP_BITS'(1) << (FRAC_BITS - 4);
    localparam logic [STEP_BITS-1:0] STEP_MAX   = STEP_BITS'(1) << (FRAC_BITS + 4);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_of_run;
        logic                          end_of_output;
    } out_beat_t;

    typedef struct packed {
        logic                          mul_en;
        logic signed [SAMPLE_BITS-1:0] prev;
        logic signed [SAMPLE_BITS-1:0] cur;
        logic [FRAC_BITS-1:0]          frac;
    } interp_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_INTERP,
        ST_TAIL
    } seq_state_t;

endpackage

/* sv/lir_interp.sv */
`timescale 1ns / 1ps

module lir_interp (
    input  logic                                   clk,
    input  lir_pkg::interp_ctrl_t                  ctrl,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] result
);
    import lir_pkg::*;

    localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   biased;
    logic signed [SAMPLE_BITS+1:0] q;
    logic signed [SAMPLE_BITS+1:0] sum;

    assign diff      = {ctrl.cur[SAMPLE_BITS-1], ctrl.cur}
                     - {ctrl.prev[SAMPLE_BITS-1], ctrl.prev};
    assign prod_next = diff * $signed({1'b0, ctrl.frac});

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // round to nearest, ties upward: floor((p + half) / 2^F)
    assign biased = prod_reg + HALF;
    assign q      = biased[PROD_BITS-1:FRAC_BITS];
    assign sum    = {{2{ctrl.prev[SAMPLE_BITS-1]}}, ctrl.prev} + q;
    assign result = sum[SAMPLE_BITS-1:0];

endmodule

/* sv/lir_ctrl.sv */
`timescale 1ns / 1ps

module lir_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  lir_pkg::in_beat_t                      in_data,
    input  logic                                   cfg_valid,
    input  logic [lir_pkg::STEP_BITS-1:0]          cfg_data,
    input  logic                                   slot_free,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] interp_result,
    output logic                                   out_load,
    output lir_pkg::out_beat_t                     out_beat,
    output lir_pkg::interp_ctrl_t                  ictrl
);
    import lir_pkg::*;

    seq_state_t state_reg, state_next;

    logic [STEP_BITS-1:0]          step_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic                          end_reg, end_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic                          await_reg, await_next;

    logic [STEP_BITS-1:0] step_eff;
    logic [POS_BITS-1:0]  pos_step;
    logic [POS_BITS-1:0]  pos_wrap;
    logic [POS_BITS-1:0]  pos_less;

    always_comb
    begin
        if (step_reg < STEP_MIN)
            step_eff = STEP_MIN;
        else if (step_reg > STEP_MAX)
            step_eff = STEP_MAX;
        else
            step_eff = step_reg;
    end

    // pos < one here, so pos + step stays below 2^(F+5)
    assign pos_step = pos_reg + POS_BITS'(step_eff);
    assign pos_wrap = pos_step - ONE_POS;
    assign pos_less = pos_reg - ONE_POS;

    assign in_stall = (state_reg != ST_IDLE);

    assign ictrl.mul_en = (state_reg == ST_MUL);
    assign ictrl.prev   = prev_reg;
    assign ictrl.cur    = cur_reg;
    assign ictrl.frac   = pos_reg[FRAC_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (await_reg)
                        state_next = in_data.end_of_input ? ST_TAIL : ST_IDLE;
                    else if (pos_reg < ONE_POS)
                        state_next = ST_MUL;
                    else if (in_data.end_of_input && (pos_less < ONE_POS))
                        state_next = ST_TAIL;
                end
            end
            ST_MUL:
                state_next = ST_INTERP;
            ST_INTERP:
            begin
                if (slot_free)
                begin
                    if (pos_step < ONE_POS)
                        state_next = ST_MUL;
                    else if (end_reg && (pos_wrap < ONE_POS))
                        state_next = ST_TAIL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (slot_free && (pos_step >= ONE_POS))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        pos_next   = pos_reg;
        await_next = await_reg;
        out_load   = 1'b0;
        out_beat   = '{sample_out: cur_reg, last_of_run: 1'b0, end_of_output: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next = in_data.sample_in;
                    end_next = in_data.end_of_input;
                    if (await_reg)
                    begin
                        await_next = 1'b0;
                        prev_next  = in_data.sample_in;
                    end
                    else if (pos_reg >= ONE_POS)
                    begin
                        pos_next  = pos_less;
                        prev_next = in_data.sample_in;
                        // end of stream with nothing left to emit
                        if (in_data.end_of_input && (pos_less >= ONE_POS))
                        begin
                            prev_next  = '0;
                            pos_next   = '0;
                            await_next = 1'b1;
                        end
                    end
                end
            end
            ST_MUL:
            begin
            end
            ST_INTERP:
            begin
                if (slot_free)
                begin
                    out_load            = 1'b1;
                    out_beat.sample_out = interp_result;
                    if (pos_step < ONE_POS)
                        pos_next = pos_step;
                    else
                    begin
                        pos_next  = pos_wrap;
                        prev_next = cur_reg;
                        if (!(end_reg && (pos_wrap < ONE_POS)))
                        begin
                            out_beat.last_of_run   = 1'b1;
                            out_beat.end_of_output = end_reg;
                            if (end_reg)
                            begin
                                prev_next  = '0;
                                pos_next   = '0;
                                await_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (pos_step < ONE_POS)
                        pos_next = pos_step;
                    else
                    begin
                        out_beat.last_of_run   = 1'b1;
                        out_beat.end_of_output = 1'b1;
                        prev_next  = '0;
                        pos_next   = '0;
                        await_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_RESET;
            prev_reg  <= '0;
            pos_reg   <= '0;
            await_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            pos_reg   <= pos_next;
            await_reg <= await_next;
            if (cfg_valid)
                step_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        end_reg <= end_next;
    end

    a_mul_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (pos_reg < ONE_POS))
        else $error("multiply issued for a position past the interval");

    a_tail_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAIL) |-> (end_reg && (pos_reg < ONE_POS)))
        else $error("tail outputs outside the final interval");

    a_fresh_stream: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> ((pos_reg == '0) && (prev_reg == '0)))
        else $error("stream state not cleared while awaiting first sample");

    a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> ((state_reg == ST_INTERP) || (state_reg == ST_TAIL)))
        else $error("output beat loaded outside an emitting state");

endmodule

/* sv/linear_interp_resampler.sv */
`timescale 1ns / 1ps

// Linear-interpolation resampler, one mono Q1.23 channel. Outputs fall at
// source positions 0, s, 2s, ... with s = step (Q5.16, clamped to 1/16..16),
// to be loaded through the config channel while the block is idle; the block
// itself does not enforce this. One shared multiplier, driven by a small
// sequencer, works out each interpolated beat: multiply, then round and load
// the output register. Trailing outputs after an end-of-input beat are loaded
// directly, and the input is taken while idle. An input holds in_stall until
// all the outputs it causes are loaded, longer if the output side stalls. The
// first sample of a stream only primes the interpolator, unless it also ends
// the stream. A single output register decouples the two sides.
module linear_interp_resampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lir_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lir_pkg::out_beat_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lir_pkg::STEP_BITS-1:0]     cfg_data
);
    import lir_pkg::*;

    interp_ctrl_t                  ictrl;
    logic signed [SAMPLE_BITS-1:0] interp_result;
    logic                          out_load;
    out_beat_t                     out_beat;
    logic                          slot_free;
    logic                          out_valid_reg;
    out_beat_t                     out_data_reg;

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;

    lir_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .slot_free     (slot_free),
        .interp_result (interp_result),
        .out_load      (out_load),
        .out_beat      (out_beat),
        .ictrl         (ictrl)
    );

    lir_interp u_interp (
        .clk    (clk),
        .ctrl   (ictrl),
        .result (interp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= out_beat;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* verif/lir_checker.sv */
`timescale 1ns / 1ps

module lir_checker
    import lir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_beat_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_beat_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [STEP_BITS-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   outstanding,
    output int                   result_count
);

    out_beat_t                     resampled_q[$];
    logic [STEP_BITS-1:0]          step_reg;
    logic signed [SAMPLE_BITS-1:0] last_sample;
    logic [POS_BITS-1:0]           next_pos;
    logic                          fresh_stream;

    function automatic logic [STEP_BITS-1:0] clamp_step(input logic [STEP_BITS-1:0] s);
        if (s < STEP_MIN)
            return STEP_MIN;
        if (s > STEP_MAX)
            return STEP_MAX;
        return s;
    endfunction

    // a + round((b - a) * f / 2^FRAC_BITS), ties upward
    function automatic logic signed [SAMPLE_BITS-1:0] lerp(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic [FRAC_BITS-1:0]          f
    );
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(f);
        prod = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return SAMPLE_BITS'(longint'(a) + prod);
    endfunction

    task automatic resample_beat(input in_beat_t b);
        out_beat_t            run_q[$];
        out_beat_t            r;
        logic [STEP_BITS-1:0] step;
        int                   n;
        step = clamp_step(step_reg);
        r.last_of_run   = 1'b0;
        r.end_of_output = 1'b0;
        if (fresh_stream)
        begin
            fresh_stream = 1'b0;
            next_pos     = '0;
        end
        else
        begin
            while (next_pos < ONE_POS)
            begin
                r.sample_out = lerp(last_sample, b.sample_in, next_pos[FRAC_BITS-1:0]);
                run_q = {run_q, r};
                next_pos = next_pos + POS_BITS'(step);
            end
            next_pos = next_pos - ONE_POS;
        end
        last_sample = b.sample_in;
        n = run_q.size();
        if (b.end_of_input)
        begin
            // tail: final sample alone up to one past its index
            while (next_pos < ONE_POS)
            begin
                r.sample_out = b.sample_in;
                run_q = {run_q, r};
                next_pos = next_pos + POS_BITS'(step);
            end
            n = run_q.size();
            if (n > 0)
            begin
                r = run_q[n-1];
                r.end_of_output = 1'b1;
                run_q[n-1] = r;
            end
            last_sample  = '0;
            next_pos     = '0;
            fresh_stream = 1'b1;
        end
        if (n > 0)
        begin
            r = run_q[n-1];
            r.last_of_run = 1'b1;
            run_q[n-1] = r;
        end
        resampled_q = {resampled_q, run_q};
    endtask

    task automatic note_mismatch(input string what, input out_beat_t exp_b, input out_beat_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected sample %0d last %0b end %0b, %s %0d last %0b end %0b",
                     $realtime, what, exp_b.sample_out, exp_b.last_of_run,
                     exp_b.end_of_output, "got sample",
                     got.sample_out, got.last_of_run, got.end_of_output);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t exp_b;
        if (!rst_n)
        begin
            resampled_q.delete();
            step_reg       = STEP_RESET;
            last_sample    = '0;
            next_pos       = '0;
            fresh_stream   = 1'b1;
            mismatch_count = 0;
            result_count   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                step_reg = cfg_data;
            if (in_valid && !in_stall)
                resample_beat(in_data);
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (resampled_q.size() == 0)
                begin
                    exp_b = '0;
                    note_mismatch("unexpected beat", exp_b, out_data);
                end
                else
                begin
                    exp_b = resampled_q.pop_front();
                    if (out_data.sample_out !== exp_b.sample_out
                        || out_data.last_of_run !== exp_b.last_of_run
                        || out_data.end_of_output !== exp_b.end_of_output)
                        note_mismatch("beat mismatch", exp_b, out_data);
                end
            end
        end
        outstanding = resampled_q.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lir_pkg::*;

    localparam int RAND_ITEMS    = 160;
    localparam int QUIET_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_beat_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [STEP_BITS-1:0] cfg_data;

    int   mismatch_count;
    int   outstanding;
    int   result_count;
    int   beats_sent;
    int   step_writes;
    logic quiet;

    linear_interp_resampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lir_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .result_count   (result_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // sink stalls in bursts, with stall-free stretches between
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return STEP_BITS'($urandom_range(0, 4095));
            1:       return STEP_BITS'($urandom_range(1048577, 2097151));
            2:       return ($urandom_range(0, 1) != 0) ? STEP_MIN : STEP_MAX;
            default: return STEP_BITS'($urandom_range(4096, 262144));
        endcase
    endfunction

    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic eoi);
        in_beat_t b;
        b.sample_in    = s;
        b.end_of_input = eoi;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // idle the input, wait out every expected beat plus some slack
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_BITS-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_writes++;
    endtask

    initial
    begin
        int n_items;
        int len;
        int total;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        quiet        = 1'b0;
        beats_sent   = 0;
        step_writes  = 0;
        n_items      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit step from reset, full-scale swings
        send_beat(24'sh7FFFFF, 1'b0);
        send_beat(-24'sh800000, 1'b0);
        send_beat(24'sh7FFFFF, 1'b1);

        // half step: rounding ties either side of zero
        write_step(STEP_BITS'(32768));
        send_beat(24'sd0, 1'b0);
        send_beat(24'sd1, 1'b0);
        send_beat(24'sd0, 1'b0);
        send_beat(-24'sd1, 1'b0);
        send_beat(24'sd0, 1'b1);

        // zero step clamps to 1/16: most beats from one input
        write_step('0);
        send_beat(-24'sh800000, 1'b0);
        send_beat(24'sh7FFFFF, 1'b1);

        // all-ones step clamps to 16: end beat gives nothing, lone sample stream
        write_step({STEP_BITS{1'b1}});
        send_beat(24'sd100, 1'b0);
        send_beat(24'sd200, 1'b0);
        send_beat(24'sd300, 1'b0);
        send_beat(24'sd400, 1'b1);
        send_beat(24'sd5, 1'b1);

        write_step(STEP_MIN);
        send_beat(-24'sd1, 1'b1);

        // step changed part way through a stream
        write_step(STEP_BITS'(196608));
        send_beat(24'sd1000, 1'b0);
        send_beat(-24'sd3000, 1'b0);
        send_beat(24'sd7, 1'b0);
        write_step(STEP_BITS'(12345));
        send_beat(24'sd5000, 1'b0);
        send_beat(24'sh400000, 1'b0);
        send_beat(-24'sh123456, 1'b1);

        write_step(STEP_MAX);
        send_beat(24'sd42, 1'b0);
        send_beat(-24'sd42, 1'b1);

        write_step(STEP_RESET);

        while (n_items < RAND_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_step(pick_step());
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if (n_items >= RAND_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
                if (i > 0 && $urandom_range(0, 15) == 0)
                    write_step(pick_step());
                // mostly terminated streams, some left open into the next
                send_beat(pick_sample(), (i == len - 1) && ($urandom_range(0, 7) != 0));
                n_items++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        total = mismatch_count + outstanding;
        if (outstanding != 0)
            $display("%0d expected beats never arrived", outstanding);
        $display("Run covered %0d input beats and %0d output beats", beats_sent, result_count);
        $display("over %0d step writes, clamped extremes and mid-stream changes included",
                 step_writes);
        if (total == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
sv/lir_pkg.sv
sv/lir_interp.sv
sv/lir_ctrl.sv
sv/linear_interp_resampler.sv
verif/lir_checker.sv
verif/tb_top.sv
